### rtl/intel_hex_record_loader_defines.svh
// Assertion macros for the HEX record loader
`ifndef INTEL_HEX_RECORD_LOADER_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HXL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HXL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HXL_ASSERT(label, prop, msg)
`define HXL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/hxl_pkg.sv
// Shared types and constants for the HEX record loader
package hxl_pkg;

  localparam int unsigned IMAGE_SIZE_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic       OP_CHAR = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [1:0] PHASE_WAIT  = 2'd0;
  localparam logic [1:0] PHASE_INREC = 2'd1;
  localparam logic [1:0] PHASE_EOF   = 2'd2;
  localparam logic [1:0] PHASE_ERR   = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_COLON = 3'd1;
  localparam logic [2:0] ERR_BAD_DIG  = 3'd2;
  localparam logic [2:0] ERR_SHORT    = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;
  localparam logic [2:0] ERR_OUTSIDE  = 3'd5;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;
  localparam logic [7:0] REC_LIN  = 8'h04;

  typedef enum logic [1:0] {
    CK_COLON,
    CK_EOL,
    CK_HEX,
    CK_BAD
  } char_kind_t;

  typedef struct packed {
    logic        opcode;
    char_kind_t  kind;
    logic [3:0]  digit;
    logic [15:0] addr;
  } item_t;

endpackage

### rtl/hxl_front.sv
// Front end: classifies each incoming character
module hxl_front (
  input  logic                opcode,
  input  logic [7:0]          text_char,
  input  logic [15:0]         read_address,
  output hxl_pkg::item_t      item
);

  always_comb begin
    item.opcode = opcode;
    item.addr   = read_address;
    item.digit  = 4'd0;
    item.kind   = hxl_pkg::CK_BAD;
    if (text_char == 8'h3a) begin
      item.kind = hxl_pkg::CK_COLON;
    end else if (text_char == 8'h0d || text_char == 8'h0a) begin
      item.kind = hxl_pkg::CK_EOL;
    end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
      item.kind  = hxl_pkg::CK_HEX;
      item.digit = 4'(text_char - 8'h30);
    end else if (text_char >= 8'h61 && text_char <= 8'h66) begin
      item.kind  = hxl_pkg::CK_HEX;
      item.digit = 4'(text_char - 8'h57);
    end else if (text_char >= 8'h41 && text_char <= 8'h46) begin
      item.kind  = hxl_pkg::CK_HEX;
      item.digit = 4'(text_char - 8'h37);
    end
  end

endmodule

### rtl/hxl_queue.sv
// Short FIFO between the front end and the back end
module hxl_queue #(
  parameter int unsigned DEPTH = hxl_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hxl_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hxl_pkg::item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hxl_pkg::item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/hxl_back.sv
// Back end: record parser, record buffer, image memory and result register
module hxl_back #(
  parameter int unsigned IMAGE_SIZE = hxl_pkg::IMAGE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  hxl_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     phase,
  output logic [2:0]     error_kind,
  output logic           record_accepted,
  output logic [7:0]     read_data,
  output logic [16:0]    used_start,
  output logic [15:0]    used_end
);

  localparam int unsigned AW = $clog2(IMAGE_SIZE);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_COPY, S_OUT} state_t;
  typedef enum logic [3:0] {
    P_WAIT, P_LEN, P_OFFH, P_OFFL, P_TYPE, P_DATA, P_SUM, P_EOF, P_ERR
  } parse_t;

  state_t      state;
  parse_t      pphase, pphase_next;
  logic [3:0]  acc, acc_next;
  logic        low_nib, low_nib_next;
  logic [7:0]  rec_len, rec_len_next;
  logic [7:0]  off_hi, off_hi_next;
  logic [32:0] rec_start, rec_start_next;
  logic [7:0]  rec_type, rec_type_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  byte_cnt, byte_cnt_next;
  logic [7:0]  base_hi, base_hi_next, base_lo, base_lo_next;
  logic [31:0] base_addr, base_addr_next;
  logic [AW:0]   lowest, lowest_next;
  logic [AW-1:0] highest, highest_next;
  logic [2:0]  err, err_next;
  logic        acc_ok, copy_go;

  logic [7:0]  byte_val, sum_add;
  logic [33:0] stop;

  logic [7:0]  rec_buf [256];
  logic        buf_we;
  logic [7:0]  buf_q;
  logic [7:0]  img_mem [IMAGE_SIZE];
  logic [7:0]  img_q;
  logic [8:0]  cp_rd;
  logic        cp_wv;
  logic [AW-1:0] cp_wa;
  logic        rd_in_range;

  assign item_ready = (state == S_IDLE);
  assign byte_val   = {acc, item.digit};
  assign sum_add    = sum + byte_val;
  assign stop       = {1'b0, rec_start} + 34'(rec_len);

  // Parser step for one character
  always_comb begin
    pphase_next    = pphase;
    acc_next       = acc;
    low_nib_next   = low_nib;
    rec_len_next   = rec_len;
    off_hi_next    = off_hi;
    rec_start_next = rec_start;
    rec_type_next  = rec_type;
    sum_next       = sum;
    byte_cnt_next  = byte_cnt;
    base_hi_next   = base_hi;
    base_lo_next   = base_lo;
    base_addr_next = base_addr;
    lowest_next    = lowest;
    highest_next   = highest;
    err_next       = err;
    acc_ok         = 1'b0;
    copy_go        = 1'b0;
    buf_we         = 1'b0;
    case (pphase)
      P_EOF, P_ERR: begin
      end
      P_WAIT: begin
        if (item.kind == hxl_pkg::CK_COLON) begin
          pphase_next  = P_LEN;
          low_nib_next = 1'b0;
          acc_next     = 4'd0;
        end else if (item.kind != hxl_pkg::CK_EOL) begin
          err_next    = hxl_pkg::ERR_NO_COLON;
          pphase_next = P_ERR;
        end
      end
      default: begin
        if (item.kind == hxl_pkg::CK_COLON || item.kind == hxl_pkg::CK_EOL) begin
          err_next    = hxl_pkg::ERR_SHORT;
          pphase_next = P_ERR;
        end else if (item.kind == hxl_pkg::CK_BAD) begin
          err_next    = hxl_pkg::ERR_BAD_DIG;
          pphase_next = P_ERR;
        end else if (!low_nib) begin
          acc_next     = item.digit;
          low_nib_next = 1'b1;
        end else begin
          low_nib_next = 1'b0;
          acc_next     = item.digit;
          sum_next     = sum_add;
          case (pphase)
            P_LEN: begin
              rec_len_next = byte_val;
              sum_next     = byte_val;
              pphase_next  = P_OFFH;
            end
            P_OFFH: begin
              off_hi_next = byte_val;
              pphase_next = P_OFFL;
            end
            P_OFFL: begin
              rec_start_next = 33'(base_addr) + 33'({off_hi, byte_val});
              pphase_next    = P_TYPE;
            end
            P_TYPE: begin
              rec_type_next = byte_val;
              byte_cnt_next = 8'd0;
              base_hi_next  = 8'd0;
              base_lo_next  = 8'd0;
              pphase_next   = (rec_len != 8'd0) ? P_DATA : P_SUM;
            end
            P_DATA: begin
              buf_we        = 1'b1;
              byte_cnt_next = byte_cnt + 8'd1;
              if (byte_cnt == 8'd0) base_hi_next = byte_val;
              if (byte_cnt == 8'd1) base_lo_next = byte_val;
              if (byte_cnt + 8'd1 == rec_len) pphase_next = P_SUM;
            end
            P_SUM: begin
              if (sum_add != 8'd0) begin
                err_next    = hxl_pkg::ERR_CHECKSUM;
                pphase_next = P_ERR;
              end else begin
                pphase_next = P_WAIT;
                acc_ok      = 1'b1;
                case (rec_type)
                  hxl_pkg::REC_DATA: begin
                    if (stop > 34'(IMAGE_SIZE)) begin
                      err_next    = hxl_pkg::ERR_OUTSIDE;
                      pphase_next = P_ERR;
                      acc_ok      = 1'b0;
                    end else if (rec_len != 8'd0) begin
                      copy_go = 1'b1;
                      if ((AW+1)'(rec_start) < lowest) lowest_next = (AW+1)'(rec_start);
                      if (AW'(stop - 34'd1) > highest) highest_next = AW'(stop - 34'd1);
                    end
                  end
                  hxl_pkg::REC_EOF: pphase_next = P_EOF;
                  hxl_pkg::REC_SEG: base_addr_next = {12'd0, base_hi, base_lo, 4'd0};
                  hxl_pkg::REC_LIN: base_addr_next = {base_hi, base_lo, 16'd0};
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we && state == S_IDLE && item_valid) begin
      rec_buf[byte_cnt] <= byte_val;
    end
    buf_q <= rec_buf[cp_rd[7:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY && cp_wv) begin
      img_mem[cp_wa] <= buf_q;
    end
    img_q <= img_mem[AW'(item.addr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pphase          <= P_WAIT;
      acc             <= 4'd0;
      low_nib         <= 1'b0;
      rec_len         <= 8'd0;
      off_hi          <= 8'd0;
      rec_start       <= 33'd0;
      rec_type        <= 8'd0;
      sum             <= 8'd0;
      byte_cnt        <= 8'd0;
      base_hi         <= 8'd0;
      base_lo         <= 8'd0;
      base_addr       <= 32'd0;
      lowest          <= (AW+1)'(IMAGE_SIZE);
      highest         <= '0;
      err             <= hxl_pkg::ERR_NONE;
      cp_rd           <= 9'd0;
      cp_wv           <= 1'b0;
      cp_wa           <= '0;
      rd_in_range     <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= hxl_pkg::PHASE_WAIT;
      error_kind      <= hxl_pkg::ERR_NONE;
      record_accepted <= 1'b0;
      read_data       <= 8'd0;
      used_start      <= 17'(IMAGE_SIZE);
      used_end        <= 16'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.opcode == hxl_pkg::OP_READ) begin
              rd_in_range <= (32'(item.addr) < 32'(IMAGE_SIZE));
              state       <= S_READ;
            end else begin
              pphase    <= pphase_next;
              acc       <= acc_next;
              low_nib   <= low_nib_next;
              rec_len   <= rec_len_next;
              off_hi    <= off_hi_next;
              rec_start <= rec_start_next;
              rec_type  <= rec_type_next;
              sum       <= sum_next;
              byte_cnt  <= byte_cnt_next;
              base_hi   <= base_hi_next;
              base_lo   <= base_lo_next;
              base_addr <= base_addr_next;
              lowest    <= lowest_next;
              highest   <= highest_next;
              err       <= err_next;
              record_accepted <= acc_ok;
              read_data       <= 8'd0;
              error_kind      <= err_next;
              used_start      <= 17'(lowest_next);
              used_end        <= 16'(highest_next);
              case (pphase_next)
                P_WAIT:  phase <= hxl_pkg::PHASE_WAIT;
                P_EOF:   phase <= hxl_pkg::PHASE_EOF;
                P_ERR:   phase <= hxl_pkg::PHASE_ERR;
                default: phase <= hxl_pkg::PHASE_INREC;
              endcase
              if (copy_go) begin
                cp_rd <= 9'd0;
                cp_wv <= 1'b0;
                state <= S_COPY;
              end else begin
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
            end
          end
        end
        S_READ: begin
          read_data       <= rd_in_range ? img_q : 8'd0;
          record_accepted <= 1'b0;
          error_kind      <= err;
          used_start      <= 17'(lowest);
          used_end        <= 16'(highest);
          case (pphase)
            P_WAIT:  phase <= hxl_pkg::PHASE_WAIT;
            P_EOF:   phase <= hxl_pkg::PHASE_EOF;
            P_ERR:   phase <= hxl_pkg::PHASE_ERR;
            default: phase <= hxl_pkg::PHASE_INREC;
          endcase
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_COPY: begin
          // issue one buffer read a cycle, write each byte into the image in the following cycle
          if (cp_rd != {1'b0, rec_len}) begin
            cp_rd <= cp_rd + 9'd1;
            cp_wv <= 1'b1;
            cp_wa <= AW'(rec_start) + AW'(cp_rd);
          end else begin
            cp_wv <= 1'b0;
            if (!cp_wv) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/intel_hex_record_loader.sv
// Intel HEX loader: one result per item, in item order.
// Character item: the result is registered as the back end takes the item from the
// queue head; a good data record first copies its bytes from the record buffer to the image (one byte a cycle).
// Read item: the image memory read port is registered, so the result passes through the S_READ state.
// A 2-entry queue takes items while the back end works or the result waits.
// Synchronous reset clears parser state, base, used range and errors.
`include "intel_hex_record_loader_defines.svh"
module intel_hex_record_loader #(
  parameter int unsigned IMAGE_SIZE = hxl_pkg::IMAGE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  text_char,
  input  logic [15:0] read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  phase,
  output logic [2:0]  error_kind,
  output logic        record_accepted,
  output logic [7:0]  read_data,
  output logic [16:0] used_start,
  output logic [15:0] used_end
);

  hxl_pkg::item_t front_item, head_item;
  logic           head_valid, head_ready;

  hxl_front u_front (
    .opcode       (opcode),
    .text_char    (text_char),
    .read_address (read_address),
    .item         (front_item)
  );

  hxl_queue #(.DEPTH(hxl_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  hxl_back #(.IMAGE_SIZE(IMAGE_SIZE)) u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (head_valid),
    .item_ready      (head_ready),
    .item            (head_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase           (phase),
    .error_kind      (error_kind),
    .record_accepted (record_accepted),
    .read_data       (read_data),
    .used_start      (used_start),
    .used_end        (used_end)
  );

  `HXL_ASSERT(a_acc_no_err, out_valid && record_accepted |-> error_kind == hxl_pkg::ERR_NONE, "accepted record with error")
  `HXL_ASSERT(a_err_code, out_valid && phase == hxl_pkg::PHASE_ERR |-> error_kind != hxl_pkg::ERR_NONE, "error phase without code")
  `HXL_ASSERT_ALWAYS(a_acc_phase, out_valid && record_accepted |-> phase == hxl_pkg::PHASE_WAIT || phase == hxl_pkg::PHASE_EOF, "accepted record in bad phase")

endmodule

### tb/tb_intel_hex_record_loader.sv
// Self-checking testbench for the Intel HEX record loader: directed table, then random records
module tb_intel_hex_record_loader;
  timeunit 1ns;
  timeprecision 1ps;
  import hxl_pkg::*;

  localparam int IMG = 65536;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_CHARS = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OP_CHAR;
  logic [7:0]  text_char = 8'h00;
  logic [15:0] read_address = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  phase;
  logic [2:0]  error_kind;
  logic        record_accepted;
  logic [7:0]  read_data;
  logic [16:0] used_start;
  logic [15:0] used_end;

  intel_hex_record_loader dut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  err;
    logic        acc;
    logic [7:0]  data;
    logic [16:0] ustart;
    logic [15:0] uend;
  } loader_result_t;

  typedef enum int {
    S_WAIT, S_LEN, S_OFFH, S_OFFL, S_TYPE, S_DATA, S_SUM, S_EOF, S_ERR
  } parse_state_t;

  // Loader state as the testbench sees it
  parse_state_t ps;
  logic [7:0]  nib;
  logic        low_next;
  logic [7:0]  r_len, r_type, r_sum, r_cnt;
  logic [15:0] r_off;
  logic [31:0] base;
  logic [7:0]  rbuf [256];
  logic [7:0]  image [IMG];
  bit          written [IMG];
  int          lowest, highest;
  logic [2:0]  sticky;
  int          written_addrs[$];

  loader_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int chars_sent = 0;

  function automatic void raise_err(logic [2:0] kind);
    sticky = kind;
    ps = S_ERR;
  endfunction

  function automatic logic commit_record();
    longint start, stop;
    logic [15:0] bv;
    ps = S_WAIT;
    bv = {(r_len >= 1) ? rbuf[0] : 8'h00, (r_len >= 2) ? rbuf[1] : 8'h00};
    if (r_type == REC_DATA) begin
      start = longint'(base) + r_off;
      stop = start + r_len;
      if (stop > IMG) begin
        raise_err(ERR_OUTSIDE);
        return 1'b0;
      end
      if (r_len == 0) return 1'b1;
      for (int i = 0; i < r_len; i++) begin
        image[start + i] = rbuf[i];
        if (!written[start + i]) begin
          written[start + i] = 1'b1;
          if (written_addrs.size() < 4096) written_addrs.push_back(int'(start + i));
          else written_addrs[$urandom_range(0, 4095)] = int'(start + i);
        end
      end
      if (start < lowest) lowest = int'(start);
      if (stop - 1 > highest) highest = int'(stop - 1);
    end else if (r_type == REC_EOF) begin
      ps = S_EOF;
    end else if (r_type == REC_SEG) begin
      base = {16'h0, bv} << 4;
    end else if (r_type == REC_LIN) begin
      base = {bv, 16'h0};
    end
    return 1'b1;
  endfunction

  function automatic logic take_byte(logic [7:0] b);
    r_sum = r_sum + b;
    case (ps)
      S_LEN: begin
        r_len = b;
        r_sum = b;
        ps = S_OFFH;
      end
      S_OFFH: begin
        r_off = {b, 8'h00};
        ps = S_OFFL;
      end
      S_OFFL: begin
        r_off[7:0] = b;
        ps = S_TYPE;
      end
      S_TYPE: begin
        r_type = b;
        r_cnt = 0;
        ps = (r_len != 0) ? S_DATA : S_SUM;
      end
      S_DATA: begin
        rbuf[r_cnt] = b;
        r_cnt = r_cnt + 1;
        if (r_cnt == r_len) ps = S_SUM;
      end
      S_SUM: begin
        if (r_sum != 0) begin
          raise_err(ERR_CHECKSUM);
          return 1'b0;
        end
        return commit_record();
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic loader_result_t snapshot(logic acc, logic [7:0] data);
    loader_result_t r;
    case (ps)
      S_WAIT:  r.phase = PHASE_WAIT;
      S_EOF:   r.phase = PHASE_EOF;
      S_ERR:   r.phase = PHASE_ERR;
      default: r.phase = PHASE_INREC;
    endcase
    r.err = sticky;
    r.acc = acc;
    r.data = data;
    r.ustart = lowest[16:0];
    r.uend = highest[15:0];
    return r;
  endfunction

  function automatic loader_result_t hex_char_step(logic [7:0] c);
    int d;
    logic acc;
    acc = 1'b0;
    if (ps == S_EOF || ps == S_ERR) begin
    end else if (ps == S_WAIT) begin
      if (c == ":") begin
        ps = S_LEN;
        low_next = 1'b0;
        nib = 8'h00;
      end else if (c != 8'h0d && c != 8'h0a) begin
        raise_err(ERR_NO_COLON);
      end
    end else if (c == ":" || c == 8'h0d || c == 8'h0a) begin
      raise_err(ERR_SHORT);
    end else begin
      d = digit_of(c);
      if (d < 0) raise_err(ERR_BAD_DIG);
      else if (!low_next) begin
        nib = 8'(d);
        low_next = 1'b1;
      end else begin
        low_next = 1'b0;
        nib = {nib[3:0], 4'(d)};
        acc = take_byte(nib);
      end
    end
    return snapshot(acc, 8'h00);
  endfunction

  function automatic loader_result_t image_read_step(logic [15:0] a);
    return snapshot(1'b0, image[a]);
  endfunction

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;

  task automatic send_beat(logic op, logic [7:0] ch, logic [15:0] addr, bit fixed = 0,
                           logic [1:0] e_phase = '0, logic [2:0] e_err = '0,
                           logic e_acc = 1'b0);
    loader_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    text_char <= ch;
    read_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = (op == OP_CHAR) ? hex_char_step(ch) : image_read_step(addr);
    if (fixed) begin
      r.phase = e_phase;
      r.err = e_err;
      r.acc = e_acc;
    end
    pending_results.push_back(r);
    if (op == OP_CHAR) chars_sent++;
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit lower);
    if (n < 10) return "0" + n;
    return (lower ? "a" : "A") + n - 10;
  endfunction

  task automatic send_hex_byte(logic [7:0] b, bit lower);
    send_beat(OP_CHAR, hex_digit(b[7:4], lower), '0);
    send_beat(OP_CHAR, hex_digit(b[3:0], lower), '0);
  endtask

  // Emit one record; sum_skew != 0 corrupts the checksum
  task automatic send_record(logic [7:0] rtype, logic [15:0] off, int len,
                             logic [7:0] payload[$], bit lower, logic [7:0] sum_skew = 0,
                             bit fixed = 0, logic [1:0] e_phase = '0,
                             logic [2:0] e_err = '0, logic e_acc = 1'b0);
    logic [7:0] s;
    s = 8'(len) + off[15:8] + off[7:0] + rtype;
    send_beat(OP_CHAR, ":", '0);
    send_hex_byte(8'(len), lower);
    send_hex_byte(off[15:8], lower);
    send_hex_byte(off[7:0], lower);
    send_hex_byte(rtype, lower);
    for (int i = 0; i < len; i++) begin
      send_hex_byte(payload[i], lower);
      s = s + payload[i];
    end
    s = -s + sum_skew;
    send_beat(OP_CHAR, hex_digit(s[7:4], lower), '0);
    send_beat(OP_CHAR, hex_digit(s[3:0], lower), '0, fixed, e_phase, e_err, e_acc);
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 3))
      0: ;
      1: send_beat(OP_CHAR, 8'h0a, '0);
      default: begin
        send_beat(OP_CHAR, 8'h0d, '0);
        send_beat(OP_CHAR, 8'h0a, '0);
      end
    endcase
  endtask

  task automatic read_written();
    if (written_addrs.size() > 0)
      send_beat(OP_READ, 8'($urandom), 16'(written_addrs[$urandom_range(0,
                written_addrs.size() - 1)]));
  endtask

  typedef enum int { ROW_EOL, ROW_REC, ROW_READ } row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  rtype;
    logic [15:0] off;
    int          len;
    logic [7:0]  fill;
    bit          lower;
    bit          fixed;
    logic [1:0]  e_phase;
    logic [2:0]  e_err;
    logic        e_acc;
  } stim_row_t;

  stim_row_t stim_rows[$];

  task automatic run_stim_table();
    logic [7:0] bytes[$];
    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_EOL: begin
          send_beat(OP_CHAR, 8'h0d, '0);
          send_beat(OP_CHAR, 8'h0a, '0, stim_rows[i].fixed, stim_rows[i].e_phase,
                    stim_rows[i].e_err, stim_rows[i].e_acc);
        end
        ROW_READ: send_beat(OP_READ, 8'h00, stim_rows[i].off);
        ROW_REC: begin
          bytes = {};
          for (int k = 0; k < stim_rows[i].len; k++)
            bytes.push_back(stim_rows[i].fill + 8'(k));
          send_record(stim_rows[i].rtype, stim_rows[i].off, stim_rows[i].len, bytes,
                      stim_rows[i].lower, 0, stim_rows[i].fixed, stim_rows[i].e_phase,
                      stim_rows[i].e_err, stim_rows[i].e_acc);
        end
      endcase
    end
  endtask

  task automatic random_record();
    logic [7:0] bytes[$];
    logic [7:0] rtype;
    int len, room, pick;
    bit lower;
    lower = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      rtype = REC_DATA;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
      room = IMG - int'(base);
      if (len > room) len = room;
      for (int k = 0; k < len; k++) bytes.push_back(8'($urandom));
      send_record(rtype, 16'($urandom_range(0, room - len)), len, bytes, lower);
    end else if (pick < 80) begin
      // segment base stays inside the image
      len = $urandom_range(0, 3);
      bytes.push_back(8'($urandom_range(0, 15)));
      for (int k = 1; k < len; k++) bytes.push_back(8'($urandom));
      send_record(REC_SEG, 16'($urandom), len, bytes, lower);
    end else if (pick < 85) begin
      len = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) bytes.push_back((k < 2) ? 8'h00 : 8'($urandom));
      send_record(REC_LIN, 16'($urandom), len, bytes, lower);
    end else begin
      do rtype = 8'($urandom); while (rtype == REC_DATA || rtype == REC_EOF ||
                                      rtype == REC_SEG || rtype == REC_LIN);
      if (pick < 90) rtype = 8'h03;
      else if (pick < 95) rtype = 8'h05;
      len = $urandom_range(0, 6);
      for (int k = 0; k < len; k++) bytes.push_back(8'($urandom));
      send_record(rtype, 16'($urandom), len, bytes, lower);
    end
  endtask

  // Close loading: end of file or one of the sticky errors
  task automatic terminate_load();
    logic [7:0] bytes[$];
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: send_record(REC_EOF, 16'h0000, 0, bytes, 0, 0, 1, PHASE_EOF, ERR_NONE, 1'b1);
      1: begin
        do c = 8'($urandom); while (c == ":" || c == 8'h0d || c == 8'h0a);
        send_beat(OP_CHAR, c, '0, 1, PHASE_ERR, ERR_NO_COLON, 1'b0);
      end
      2: begin
        send_beat(OP_CHAR, ":", '0);
        send_beat(OP_CHAR, "1", '0);
        do c = 8'($urandom); while (digit_of(c) >= 0 || c == ":" || c == 8'h0d ||
                                    c == 8'h0a);
        send_beat(OP_CHAR, c, '0, 1, PHASE_ERR, ERR_BAD_DIG, 1'b0);
      end
      3: begin
        send_beat(OP_CHAR, ":", '0);
        repeat ($urandom_range(0, 6)) send_beat(OP_CHAR, "0", '0);
        c = ($urandom_range(0, 2) == 0) ? ":" : ($urandom_range(0, 1) ? 8'h0d : 8'h0a);
        send_beat(OP_CHAR, c, '0, 1, PHASE_ERR, ERR_SHORT, 1'b0);
      end
      4: begin
        bytes.push_back(8'($urandom));
        send_record(REC_DATA, 16'h0000, 1, bytes, 0, 8'($urandom_range(1, 255)), 1,
                    PHASE_ERR, ERR_CHECKSUM, 1'b0);
      end
      default: begin
        bytes = {8'h00, 8'h01};
        send_record(REC_LIN, 16'h0000, 2, bytes, 0);
        bytes = {8'hAA};
        send_record(REC_DATA, 16'h0000, 1, bytes, 0, 0, 1, PHASE_ERR, ERR_OUTSIDE, 1'b0);
      end
    endcase
    // the loader ignores every character after this point
    repeat (4) send_beat(OP_CHAR, 8'($urandom), '0);
    repeat (4) read_written();
  endtask

  // Receiver: stall density changes each time the low byte of stall_phase_ctr wraps
  int ready_pct = 100;
  int stall_phase_ctr = 0;
  always @(posedge clk) begin
    stall_phase_ctr <= stall_phase_ctr + 1;
    if (stall_phase_ctr[7:0] == 8'hff) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 75;
        2: ready_pct <= 40;
        default: ready_pct <= 10;
      endcase
    end
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    loader_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{phase, error_kind, record_accepted, read_data, used_start, used_end};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_intel_hex_record_loader: done, errors");
      $finish;
    end
  end

  initial begin
    ps = S_WAIT;
    nib = 0;
    low_next = 0;
    r_len = 0;
    r_type = 0;
    r_sum = 0;
    r_cnt = 0;
    r_off = 0;
    base = 0;
    lowest = IMG;
    highest = 0;
    sticky = ERR_NONE;

    stim_rows = '{
      '{ROW_EOL,  8'h00, 16'h0000, 0, 8'h00, 0, 1, PHASE_WAIT, ERR_NONE, 1'b0},
      '{ROW_REC,  REC_DATA, 16'h0000, 1, 8'h00, 0, 1, PHASE_WAIT, ERR_NONE, 1'b1},
      '{ROW_REC,  REC_DATA, 16'hFFF0, 16, 8'hF0, 0, 1, PHASE_WAIT, ERR_NONE, 1'b1},
      '{ROW_REC,  REC_DATA, 16'h1234, 0, 8'h00, 1, 1, PHASE_WAIT, ERR_NONE, 1'b1},
      '{ROW_READ, 8'h00, 16'h0000, 0, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_READ, 8'h00, 16'hFFFF, 0, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_DATA, 16'h0100, 255, 8'h5A, 1, 0, '0, '0, 1'b0},
      '{ROW_REC,  8'h03, 16'hABCD, 4, 8'h11, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  8'h05, 16'h0000, 4, 8'hFF, 1, 0, '0, '0, 1'b0},
      '{ROW_REC,  8'hFF, 16'hFFFF, 2, 8'h80, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_SEG, 16'h0000, 2, 8'h08, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_DATA, 16'h0010, 4, 8'hC3, 0, 0, '0, '0, 1'b0},
      '{ROW_READ, 8'h00, 16'h8011, 0, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_SEG, 16'h0000, 1, 8'h01, 1, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_DATA, 16'h0002, 2, 8'h7E, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_LIN, 16'h0000, 0, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_REC,  REC_LIN, 16'h0000, 2, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_READ, 8'h00, 16'h1002, 0, 8'h00, 0, 0, '0, '0, 1'b0},
      '{ROW_READ, 8'h00, 16'h01FE, 0, 8'h00, 0, 0, '0, '0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_stim_table();
    while (chars_sent < RANDOM_CHARS) begin
      random_record();
      send_eol();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) read_written();
    end
    terminate_load();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_intel_hex_record_loader: done, clean");
    else
      $display("tb_intel_hex_record_loader: done, errors");
    $finish;
  end

endmodule
